// ----- src/ppt_pkg.sv -----
package ppt_pkg;

  typedef enum logic [1:0] {
    KIND_SEARCH = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_DROP   = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  localparam int PID_W  = 22;
  localparam int PERM_W = 32;

  // request beat moving down the cell row
  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [PID_W-1:0]  pid;
    logic [PERM_W-1:0] perm;
    logic              hit;
    logic              free_seen;
    logic [PERM_W-1:0] res_perm;
  } tok_t;

  // new entry write broadcast to all cells
  typedef struct packed {
    logic              en;
    logic [PID_W-1:0]  pid;
    logic [PERM_W-1:0] perm;
  } alloc_t;

endpackage

// ----- src/ppt_cell.sv -----
module ppt_cell #(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ppt_pkg::tok_t         tok_in,
  input  logic [IDX_W-1:0]      fidx_in,
  output ppt_pkg::tok_t         tok_out,
  output logic [IDX_W-1:0]      fidx_out,
  input  ppt_pkg::alloc_t       alloc,
  input  logic [IDX_W-1:0]      alloc_idx
);
  import ppt_pkg::*;

  logic              valid;
  logic [PID_W-1:0]  pid;
  logic [PERM_W-1:0] perm;

  logic              valid_next;
  logic [PERM_W-1:0] perm_next;
  tok_t              tok_next;
  logic [IDX_W-1:0]  fidx_next;
  logic              match;
  logic              claim;

  assign match = tok_in.valid && valid && (pid == tok_in.pid) && !tok_in.hit;
  assign claim = alloc.en && (alloc_idx == IDX_W'(INDEX));

  always_comb begin
    tok_next   = tok_in;
    fidx_next  = fidx_in;
    valid_next = valid;
    perm_next  = perm;
    if (match) begin
      tok_next.hit = 1'b1;
      unique case (tok_in.kind)
        KIND_SEARCH: tok_next.res_perm = perm;
        KIND_INSERT: perm_next = perm | tok_in.perm;
        KIND_DROP:   perm_next = perm & ~tok_in.perm;
        KIND_REMOVE: begin
          tok_next.res_perm = perm;
          valid_next = 1'b0;
        end
        default:     tok_next.res_perm = perm;
      endcase
    end
    if (tok_in.valid && !valid && !tok_in.free_seen) begin
      tok_next.free_seen = 1'b1;
      fidx_next = IDX_W'(INDEX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (claim) begin
      valid <= 1'b1;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      pid  <= alloc.pid;
      perm <= alloc.perm;
    end else begin
      perm <= perm_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.kind      <= tok_next.kind;
    tok_out.pid       <= tok_next.pid;
    tok_out.perm      <= tok_next.perm;
    tok_out.hit       <= tok_next.hit;
    tok_out.free_seen <= tok_next.free_seen;
    tok_out.res_perm  <= tok_next.res_perm;
    fidx_out          <= fidx_next;
  end

endmodule

// ----- src/pid_permission_table_top.sv -----
// a request's beat is registered in every cell of the row in turn, one cell
//   per cycle; done, perm_out and status are registered from the beat that
//   leaves the last cell, and a new request is taken only once busy drops
// reset: all entries invalid, busy low; done is a single-cycle strobe and
//   the receiver cannot stall it
module pid_permission_table_top #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [21:0] pid,
  input  logic [31:0] perm,
  output logic        done,
  output logic [31:0] perm_out,
  output logic [1:0]  status
);
  import ppt_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  tok_t             tok  [TABLE_ENTRIES+1];
  logic [IDX_W-1:0] fidx [TABLE_ENTRIES+1];
  alloc_t           alloc;
  logic [IDX_W-1:0] alloc_idx;
  tok_t             tail;
  logic             accept;

  assign accept = start && !busy;

  always_comb begin
    tok[0].valid     = accept;
    tok[0].kind      = kind_t'(kind);
    tok[0].pid       = pid;
    tok[0].perm      = perm;
    tok[0].hit       = 1'b0;
    tok[0].free_seen = 1'b0;
    tok[0].res_perm  = '0;
    fidx[0]          = '0;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    ppt_cell #(
      .IDX_W (IDX_W),
      .INDEX (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .tok_in    (tok[i]),
      .fidx_in   (fidx[i]),
      .tok_out   (tok[i+1]),
      .fidx_out  (fidx[i+1]),
      .alloc     (alloc),
      .alloc_idx (alloc_idx)
    );
  end

  assign tail = tok[TABLE_ENTRIES];

  always_comb begin
    alloc.en   = tail.valid && (tail.kind == KIND_INSERT) && !tail.hit && tail.free_seen;
    alloc.pid  = tail.pid;
    alloc.perm = tail.perm;
    alloc_idx  = fidx[TABLE_ENTRIES];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= tail.valid;
      if (accept) begin
        busy <= 1'b1;
      end else if (tail.valid) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tail.valid) begin
      perm_out <= tail.res_perm;
      if (tail.kind == KIND_INSERT && !tail.hit && !tail.free_seen) begin
        status <= ST_FULL;
      end else if (tail.kind == KIND_DROP && !tail.hit) begin
        status <= ST_NOT_FOUND;
      end else begin
        status <= ST_OK;
      end
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");
  a_tail_busy: assert property (@(posedge clk) disable iff (rst) tail.valid |-> busy)
    else $error("beat in the cell row while idle");
  a_one_done: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("two results for one request");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (perm_out == '0))
    else $error("error result with nonzero mask");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("busy not raised after accept");

endmodule
